/* design/fpa_pkg.sv */
// Shared types, widths and action codes for the Q24.8 fixed-point ALU.
// Depends on nothing; every other design file imports it.
`default_nettype none
package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int PROD_BITS = 2 * WORD_BITS;

    localparam logic [3:0] ACT_ADD      = 4'd0;
    localparam logic [3:0] ACT_SUB      = 4'd1;
    localparam logic [3:0] ACT_MUL      = 4'd2;
    localparam logic [3:0] ACT_DIV      = 4'd3;
    localparam logic [3:0] ACT_MIN      = 4'd4;
    localparam logic [3:0] ACT_MAX      = 4'd5;
    localparam logic [3:0] ACT_CMP      = 4'd6;
    localparam logic [3:0] ACT_INC      = 4'd7;
    localparam logic [3:0] ACT_DEC      = 4'd8;
    localparam logic [3:0] ACT_TO_INT   = 4'd9;
    localparam logic [3:0] ACT_FROM_INT = 4'd10;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               divide_by_zero;
    } fpa_out_t;

    // Per-item information that rides alongside the divider.
    typedef struct packed {
        logic                 is_div;
        logic                 neg;
        logic [WORD_BITS-1:0] res;
        logic                 less;
        logic                 equal;
        logic                 greater;
        logic                 dz;
    } fpa_side_t;

endpackage
`default_nettype wire

/* design/fpa_prep.sv */
// Operand preparation stage: flags, simple results, product, divider operands.
// Depends on fpa_pkg.
`default_nettype none
module fpa_prep
    import fpa_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire fpa_in_t                     in_item,
    output logic                             out_valid,
    output fpa_side_t                        out_side,
    output logic                             out_is_mul,
    output logic signed [PROD_BITS-1:0]      out_prod,
    output logic [NUM_BITS-1:0]              out_num,
    output logic [WORD_BITS-1:0]             out_den
);

    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0]        simple_res;
    logic [WORD_BITS-1:0]        mag_a;
    logic [WORD_BITS-1:0]        mag_b;
    fpa_side_t                   side_next;

    logic                        valid_reg;
    fpa_side_t                   side_reg;
    logic                        is_mul_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic [NUM_BITS-1:0]         num_reg;
    logic [WORD_BITS-1:0]        den_reg;

    assign a = in_item.operand_a[WORD_BITS-1:0];
    assign b = in_item.operand_b[WORD_BITS-1:0];

    // Results that need no more than one add, shift or select.
    always_comb begin
        case (in_item.action)
            ACT_ADD:      simple_res = a + b;
            ACT_SUB:      simple_res = a - b;
            ACT_MIN:      simple_res = (a < b) ? a : b;
            ACT_MAX:      simple_res = (a > b) ? a : b;
            ACT_INC:      simple_res = a + 1'b1;
            ACT_DEC:      simple_res = a - 1'b1;
            ACT_TO_INT:   simple_res = a >>> FRAC_BITS;
            ACT_FROM_INT: simple_res = a << FRAC_BITS;
            default:      simple_res = '0;
        endcase
    end

    // Magnitudes for the unsigned divider; the most negative word maps correctly.
    assign mag_a = a[WORD_BITS-1] ? (WORD_BITS'(0) - a) : a;
    assign mag_b = b[WORD_BITS-1] ? (WORD_BITS'(0) - b) : b;

    always_comb begin
        side_next.is_div  = (in_item.action == ACT_DIV) && (b != '0);
        side_next.neg     = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        side_next.res     = simple_res;
        side_next.less    = a < b;
        side_next.equal   = a == b;
        side_next.greater = a > b;
        side_next.dz      = (in_item.action == ACT_DIV) && (b == '0);
    end

    // Valid bit clears on reset; payload just advances with the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg   <= side_next;
            is_mul_reg <= in_item.action == ACT_MUL;
            prod_reg   <= a * b;
            num_reg    <= {mag_a, FRAC_BITS'(0)};
            den_reg    <= mag_b;
        end
    end

    assign out_valid  = valid_reg;
    assign out_side   = side_reg;
    assign out_is_mul = is_mul_reg;
    assign out_prod   = prod_reg;
    assign out_num    = num_reg;
    assign out_den    = den_reg;

endmodule
`default_nettype wire

/* design/fpa_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on fpa_pkg.
`default_nettype none
module fpa_divider
    import fpa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire fpa_side_t             in_side,
    input  wire logic [NUM_BITS-1:0]   in_num,
    input  wire logic [WORD_BITS-1:0]  in_den,
    output logic                       out_valid,
    output fpa_side_t                  out_side,
    output logic [WORD_BITS-1:0]       out_quot
);

    // Entry 0 is the stage input; entry i+1 is the register of step i.
    logic                 stg_valid [NUM_BITS+1];
    fpa_side_t            stg_side  [NUM_BITS+1];
    logic [NUM_BITS-1:0]  stg_num   [NUM_BITS+1];
    logic [WORD_BITS-1:0] stg_rem   [NUM_BITS+1];
    logic [WORD_BITS-1:0] stg_den   [NUM_BITS+1];

    assign stg_valid[0] = in_valid;
    assign stg_side[0]  = in_side;
    assign stg_num[0]   = in_num;
    assign stg_rem[0]   = '0;
    assign stg_den[0]   = in_den;

    for (genvar i = 0; i < NUM_BITS; i++) begin : g_step
        logic [WORD_BITS:0]   shifted;
        logic [WORD_BITS+1:0] trial;
        logic                 fits;
        logic [WORD_BITS-1:0] rem_next;
        logic [NUM_BITS-1:0]  num_next;
        logic                 valid_reg;
        fpa_side_t            side_reg;
        logic [NUM_BITS-1:0]  num_reg;
        logic [WORD_BITS-1:0] rem_reg;
        logic [WORD_BITS-1:0] den_reg;

        // Bring down the next dividend bit and try to subtract the divisor.
        assign shifted  = {stg_rem[i], stg_num[i][NUM_BITS-1]};
        assign trial    = {1'b0, shifted} - {2'b00, stg_den[i]};
        assign fits     = !trial[WORD_BITS+1];
        assign rem_next = fits ? trial[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        assign num_next = {stg_num[i][NUM_BITS-2:0], fits};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (en) begin
                valid_reg <= stg_valid[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg <= stg_side[i];
                num_reg  <= num_next;
                rem_reg  <= rem_next;
                den_reg  <= stg_den[i];
            end
        end

        assign stg_valid[i+1] = valid_reg;
        assign stg_side[i+1]  = side_reg;
        assign stg_num[i+1]   = num_reg;
        assign stg_rem[i+1]   = rem_reg;
        assign stg_den[i+1]   = den_reg;
    end

    assign out_valid = stg_valid[NUM_BITS];
    assign out_side  = stg_side[NUM_BITS];
    assign out_quot  = stg_num[NUM_BITS][WORD_BITS-1:0];

endmodule
`default_nettype wire

/* design/fixed_point_alu_q24_8_top.sv */
// Q24.8 fixed-point ALU top level: input register, prep stage, divider stages, output register.
// One item per cycle sustained; every stage holds while the output register is full and stalled.
// The divider makes up most of the pipeline depth: one register stage per quotient bit, 40 in all.
// Reset (aresetn low, synchronous) clears all valid bits; no state survives between items.
// Depends on fpa_pkg, fpa_prep and fpa_divider.
`default_nettype none
module fixed_point_alu_q24_8_top
    import fpa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire fpa_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output fpa_out_t      m_data
);

    logic                        en;
    logic                        in_valid_reg;
    fpa_in_t                     in_reg;
    logic                        prep_valid;
    fpa_side_t                   prep_side;
    logic                        prep_is_mul;
    logic signed [PROD_BITS-1:0] prep_prod;
    logic [NUM_BITS-1:0]         prep_num;
    logic [WORD_BITS-1:0]        prep_den;
    fpa_side_t                   div_in_side;
    logic                        div_valid;
    fpa_side_t                   div_side;
    logic [WORD_BITS-1:0]        div_quot;
    logic signed [WORD_BITS-1:0] final_res;
    fpa_out_t                    out_next;
    logic                        m_valid_reg;
    fpa_out_t                    out_reg;

    // The whole pipeline advances unless a finished result is waiting.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
        end
    end

    fpa_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (in_valid_reg),
        .in_item    (in_reg),
        .out_valid  (prep_valid),
        .out_side   (prep_side),
        .out_is_mul (prep_is_mul),
        .out_prod   (prep_prod),
        .out_num    (prep_num),
        .out_den    (prep_den)
    );

    // Fold the scaled product into the result carried beside the divider.
    always_comb begin
        div_in_side = prep_side;
        if (prep_is_mul) begin
            div_in_side.res = prep_prod[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
        end
    end

    fpa_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .in_side   (div_in_side),
        .in_num    (prep_num),
        .in_den    (prep_den),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quot  (div_quot)
    );

    // Apply the quotient sign and pick the final result.
    always_comb begin
        if (div_side.is_div) begin
            final_res = div_side.neg ? (WORD_BITS'(0) - div_quot) : div_quot;
        end else begin
            final_res = div_side.res;
        end
        out_next.result_value   = 32'(final_res);
        out_next.a_less         = div_side.less;
        out_next.a_equal        = div_side.equal;
        out_next.a_greater      = div_side.greater;
        out_next.divide_by_zero = div_side.dz;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    // Exactly one ordering flag describes every delivered result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_data.a_less, m_data.a_equal, m_data.a_greater}))
        else $error("ordering flags not one-hot");

    // A divide by zero always delivers a zero result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.divide_by_zero |-> m_data.result_value == 32'sd0)
        else $error("divide by zero with nonzero result");

    // A stalled result keeps the input side closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input open while output stalled");

    // Nothing is presented in the cycle after reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
